// File: sv/bzws_pkg.sv
// Shared widths, micro-op codes, controller states and command word for the width selector.
package bzws_pkg;

  localparam int MAX_SEGMENT = 2048;
  localparam int NTPL        = 3;
  localparam int TPL_W       = 2;

  localparam int PIX_W  = 8;
  localparam int COL_W  = 11;
  localparam int HALF_W = 10;
  localparam int CODE_W = 2;
  localparam int WIN_W  = COL_W + 1;

  localparam int LEN_W  = $clog2(MAX_SEGMENT + 1);
  localparam int SUM_W  = LEN_W + PIX_W;
  // |n*A - S*m| and both of its terms fit here
  localparam int MAG_W  = LEN_W + SUM_W;
  localparam int MUL_W  = MAG_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int DEN_W  = 2 * LEN_W;
  localparam int ACC_W  = MAG_W + DEN_W;
  localparam int XW     = ACC_W + MAG_W;

  // each op picks multiplier operands; its write-back runs in the cycle after
  typedef enum logic [3:0] {
    OP_NONE,
    OP_NA,   // n * A_t
    OP_SM,   // S * m_t, then |num_t| and its sign
    OP_DEN,  // m_t * (n - m_t)
    OP_SQ,   // |num_t|^2
    OP_XLO,  // candidate square, low half, times best denominator
    OP_XHI,
    OP_YLO,  // best square, low half, times candidate denominator
    OP_YHI
  } mop_t;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_NA,
    ST_SM,
    ST_DEN,
    ST_SQ,
    ST_XLO,
    ST_XHI,
    ST_YLO,
    ST_YHI,
    ST_WAIT,
    ST_DEC,
    ST_FIN
  } state_t;

  typedef struct packed {
    mop_t             op;
    logic [TPL_W-1:0] tsel;
    logic             take;
    logic             decide;
    logic             load_out;
    logic             clear;
  } cmd_t;

endpackage

// File: sv/bzws_mul.sv
// Shared unsigned multiplier with registered product.
module bzws_mul
  import bzws_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output logic [PROD_W-1:0] p_o
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = prod_r;

endmodule

// File: sv/bzws_dpath.sv
// Datapath: segment accumulators, score terms, cross-product compare and result register.
module bzws_dpath
  import bzws_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd_i,
  input  logic [PIX_W-1:0]  pix_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [COL_W-1:0]  ctr_i,
  input  logic [HALF_W-1:0] half_n_i,
  input  logic [HALF_W-1:0] half_m_i,
  input  logic [HALF_W-1:0] half_w_i,
  output logic [CODE_W-1:0] code_o
);

  // accumulators
  logic [SUM_W-1:0] sum_r;
  logic [LEN_W-1:0] len_r;
  logic [PIX_W-1:0] first_r;
  logic             diff_r;
  logic [SUM_W-1:0] isum_r [NTPL];
  logic [LEN_W-1:0] icnt_r [NTPL];

  // score terms
  logic [MAG_W-1:0] p0_r;
  logic [MAG_W-1:0] mag_r [NTPL];
  logic             neg_r [NTPL];
  logic [DEN_W-1:0] den_r [NTPL];
  logic [SQ_W-1:0]  sq_r  [NTPL];
  logic [SQ_W-1:0]  bsq_r;
  logic [DEN_W-1:0] bden_r;
  logic             bneg_r;
  logic             bval_r;
  logic [TPL_W-1:0] best_r;
  logic [ACC_W-1:0] acc_r;
  logic [XW-1:0]    x_r;
  logic [XW-1:0]    y_r;
  logic [TPL_W-1:0] code_r;

  mop_t             wb_r;
  logic [TPL_W-1:0] wt_r;

  logic [HALF_W-1:0] half   [NTPL];
  logic [NTPL-1:0]   win;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  prod_lo;
  logic              lt;
  logic [MAG_W-1:0]  mag_nxt;
  logic [XW-1:0]     xy_nxt;
  logic              vld0;
  logic              vld_t;
  logic              pc;
  logic              pb;
  logic              greater;

  assign half[0] = half_n_i;
  assign half[1] = half_m_i;
  assign half[2] = half_w_i;

  always_comb begin
    for (int t = 0; t < NTPL; t++) begin
      win[t] = (WIN_W'(col_i) + WIN_W'(half[t]) >= WIN_W'(ctr_i)) &&
               (WIN_W'(col_i) <= WIN_W'(ctr_i) + WIN_W'(half[t]));
    end
  end

  // flat segment <=> n*Q == S*S <=> every counted pixel equals the first one
  always_ff @(posedge clk) begin
    if (!rst_n || cmd_i.clear) begin
      sum_r  <= '0;
      len_r  <= '0;
      diff_r <= 1'b0;
      for (int t = 0; t < NTPL; t++) begin
        isum_r[t] <= '0;
        icnt_r[t] <= '0;
      end
    end else if (cmd_i.take && (len_r < LEN_W'(MAX_SEGMENT))) begin
      sum_r <= sum_r + SUM_W'(pix_i);
      len_r <= len_r + LEN_W'(1);
      if (len_r == '0) begin
        first_r <= pix_i;
      end else if (pix_i != first_r) begin
        diff_r <= 1'b1;
      end
      for (int t = 0; t < NTPL; t++) begin
        if (win[t]) begin
          isum_r[t] <= isum_r[t] + SUM_W'(pix_i);
          icnt_r[t] <= icnt_r[t] + LEN_W'(1);
        end
      end
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_NA: begin
        mul_a = MUL_W'(len_r);
        mul_b = MUL_W'(isum_r[cmd_i.tsel]);
      end
      OP_SM: begin
        mul_a = MUL_W'(sum_r);
        mul_b = MUL_W'(icnt_r[cmd_i.tsel]);
      end
      OP_DEN: begin
        mul_a = MUL_W'(icnt_r[cmd_i.tsel]);
        mul_b = MUL_W'(len_r - icnt_r[cmd_i.tsel]);
      end
      OP_SQ: begin
        mul_a = MUL_W'(mag_r[cmd_i.tsel]);
        mul_b = MUL_W'(mag_r[cmd_i.tsel]);
      end
      OP_XLO: begin
        mul_a = MUL_W'(sq_r[cmd_i.tsel][MAG_W-1:0]);
        mul_b = MUL_W'(bden_r);
      end
      OP_XHI: begin
        mul_a = MUL_W'(sq_r[cmd_i.tsel][SQ_W-1:MAG_W]);
        mul_b = MUL_W'(bden_r);
      end
      OP_YLO: begin
        mul_a = MUL_W'(bsq_r[MAG_W-1:0]);
        mul_b = MUL_W'(den_r[cmd_i.tsel]);
      end
      OP_YHI: begin
        mul_a = MUL_W'(bsq_r[SQ_W-1:MAG_W]);
        mul_b = MUL_W'(den_r[cmd_i.tsel]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bzws_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (prod)
  );

  assign prod_lo = prod[MAG_W-1:0];
  assign lt      = p0_r < prod_lo;
  assign mag_nxt = lt ? (prod_lo - p0_r) : (p0_r - prod_lo);
  // high partial product sits MAG_W bits up
  assign xy_nxt  = {prod[ACC_W-1:0], {MAG_W{1'b0}}} + XW'(acc_r);

  assign vld0  = diff_r && (icnt_r[0] != '0) && (icnt_r[0] != len_r);
  assign vld_t = diff_r && (icnt_r[cmd_i.tsel] != '0) && (icnt_r[cmd_i.tsel] != len_r);

  // both positive: larger x wins; both negative: smaller x wins
  assign pc      = !neg_r[cmd_i.tsel];
  assign pb      = !bneg_r;
  assign greater = (pc && !pb) || (pc && pb && (x_r > y_r)) || (!pc && !pb && (x_r < y_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= OP_NONE;
    end else begin
      wb_r <= cmd_i.op;
    end
  end

  always_ff @(posedge clk) begin
    wt_r <= cmd_i.tsel;
    unique case (wb_r) inside
      OP_NA: p0_r <= prod_lo;
      OP_SM: begin
        mag_r[wt_r] <= mag_nxt;
        neg_r[wt_r] <= lt;
        if (wt_r == '0) bneg_r <= lt;
      end
      OP_DEN: begin
        den_r[wt_r] <= prod[DEN_W-1:0];
        if (wt_r == '0) bden_r <= prod[DEN_W-1:0];
      end
      OP_SQ: begin
        sq_r[wt_r] <= prod;
        if (wt_r == '0) bsq_r <= prod;
      end
      OP_XLO, OP_YLO: acc_r <= prod[ACC_W-1:0];
      OP_XHI: x_r <= xy_nxt;
      OP_YHI: y_r <= xy_nxt;
      default: ;
    endcase
    if (cmd_i.op == OP_NA && cmd_i.tsel == '0) begin
      best_r <= '0;
      bval_r <= vld0;
    end else if (cmd_i.decide && bval_r && vld_t && greater) begin
      best_r <= cmd_i.tsel;
      bsq_r  <= sq_r[cmd_i.tsel];
      bden_r <= den_r[cmd_i.tsel];
      bneg_r <= neg_r[cmd_i.tsel];
    end
    if (cmd_i.load_out) code_r <= best_r;
  end

  assign code_o = CODE_W'(code_r);

  a_cnt_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    (icnt_r[0] <= len_r) && (icnt_r[1] <= len_r) && (icnt_r[2] <= len_r))
    else $error("window count exceeds segment length");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_SEGMENT))
    else $error("segment length beyond cap");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.clear |=> (len_r == '0) && (sum_r == '0) && !diff_r)
    else $error("accumulators not cleared");

endmodule

// File: sv/bzws_ctrl.sv
// Controller: accumulate phase, multiplier micro-sequence for the scores, result handoff.
module bzws_ctrl
  import bzws_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last,
  input  logic out_ready,
  output logic in_ready,
  output logic out_valid,
  output cmd_t cmd_o
);

  state_t           state_r, state_nxt;
  logic [TPL_W-1:0] t_r, t_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             t_end;

  assign t_end = (t_r == TPL_W'(NTPL - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      t_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      t_r         <= t_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    t_nxt          = t_r;
    in_ready       = 1'b0;
    cmd_o.op       = OP_NONE;
    cmd_o.tsel     = t_r;
    cmd_o.take     = 1'b0;
    cmd_o.decide   = 1'b0;
    cmd_o.load_out = 1'b0;
    cmd_o.clear    = 1'b0;
    unique case (state_r)
      ST_ACC: begin
        in_ready   = 1'b1;
        cmd_o.take = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_NA;
          t_nxt     = '0;
        end
      end
      ST_NA: begin
        cmd_o.op  = OP_NA;
        state_nxt = ST_SM;
      end
      ST_SM: begin
        cmd_o.op  = OP_SM;
        state_nxt = ST_DEN;
      end
      ST_DEN: begin
        cmd_o.op  = OP_DEN;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.op = OP_SQ;
        if (t_end) begin
          state_nxt = ST_XLO;
          t_nxt     = TPL_W'(1);
        end else begin
          state_nxt = ST_NA;
          t_nxt     = t_r + TPL_W'(1);
        end
      end
      ST_XLO: begin
        cmd_o.op  = OP_XLO;
        state_nxt = ST_XHI;
      end
      ST_XHI: begin
        cmd_o.op  = OP_XHI;
        state_nxt = ST_YLO;
      end
      ST_YLO: begin
        cmd_o.op  = OP_YLO;
        state_nxt = ST_YHI;
      end
      ST_YHI: begin
        cmd_o.op  = OP_YHI;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: state_nxt = ST_DEC;   // y lands this cycle
      ST_DEC: begin
        cmd_o.decide = 1'b1;
        if (t_end) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_XLO;
          t_nxt     = t_r + TPL_W'(1);
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd_o.load_out = 1'b1;
          cmd_o.clear    = 1'b1;
          state_nxt      = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_o.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before taken");

  a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready && (cmd_o.op == OP_NA))
    else $error("scoring did not start after last word");

  a_tpl_range: assert property (@(posedge clk) disable iff (!rst_n)
    t_r != TPL_W'(NTPL))
    else $error("template index out of range");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule

// File: sv/box_template_zncc_width_select_core.sv
// Top level: box-template ZNCC width selector, controller plus datapath.
//
//   channel | direction | handshake            | word
//   in_     | input     | in_valid / in_ready  | pixel, column, center, 3 half widths, last
//   out_    | output    | out_valid / out_ready| width_code
//
// One input word per cycle while a segment accumulates. After the word marked last,
// in_ready stays low through 20 ops on the single shared multiplier, a wait and a decide
// step for each of the two later templates, plus the result load.
// Reset clears all sums and empties the result register; no clearing pass.
// A result waiting on out_ready does not block the next segment, only the load of its end.
module box_template_zncc_width_select_core
  import bzws_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic [COL_W-1:0]  in_column,
  input  logic [COL_W-1:0]  in_center,
  input  logic [HALF_W-1:0] in_half_narrow,
  input  logic [HALF_W-1:0] in_half_middle,
  input  logic [HALF_W-1:0] in_half_wide,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_width_code
);

  cmd_t cmd;

  bzws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd_o     (cmd)
  );

  bzws_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_i    (cmd),
    .pix_i    (in_pixel),
    .col_i    (in_column),
    .ctr_i    (in_center),
    .half_n_i (in_half_narrow),
    .half_m_i (in_half_middle),
    .half_w_i (in_half_wide),
    .code_o   (out_width_code)
  );

endmodule

// File: verif/tb_box_template_zncc_width_select_core.sv
// Self-checking testbench for the box-template ZNCC width selector core.
module tb_box_template_zncc_width_select_core
  import bzws_pkg::*;
;

  localparam int TAIL_WORDS     = 150;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int RANDOM_WORDS   = 1000;

  typedef enum {SEG_BOX, SEG_FLAT, SEG_NOISE, SEG_JUMP, SEG_DRIFT} seg_kind_t;

  typedef struct {
    logic [PIX_W-1:0]  pixel;
    logic [COL_W-1:0]  column;
    logic [COL_W-1:0]  center;
    logic [HALF_W-1:0] half [NTPL];
    logic              last;
    bit                drain_first;  // hold this word until all codes are back
  } pix_word_t;

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  in_pixel       = '0;
  logic [COL_W-1:0]  in_column      = '0;
  logic [COL_W-1:0]  in_center      = '0;
  logic [HALF_W-1:0] in_half_narrow = '0;
  logic [HALF_W-1:0] in_half_middle = '0;
  logic [HALF_W-1:0] in_half_wide   = '0;
  logic              in_last        = 1'b0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [CODE_W-1:0] out_width_code;

  box_template_zncc_width_select_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .in_column      (in_column),
    .in_center      (in_center),
    .in_half_narrow (in_half_narrow),
    .in_half_middle (in_half_middle),
    .in_half_wide   (in_half_wide),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_width_code (out_width_code)
  );

  pix_word_t         pixel_word_q[$];
  pix_word_t         cur_word;
  logic [CODE_W-1:0] code_expect_q[$];

  // running sums of the segment in flight
  int unsigned pix_sum, sq_sum, seg_len;
  int unsigned win_sum [NTPL];
  int unsigned win_cnt [NTPL];

  int  total_words, words_taken, seg_total, codes_seen, fail_count;
  int  code_hist [NTPL];
  int  in_gap, out_gap, quiet_cycles;
  bit  calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clamp(int v, int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  // n_a/sqrt(d_a) > n_b/sqrt(d_b), both d positive; exact via squared terms
  function automatic bit corr_greater(longint na, longint da, longint nb, longint db);
    logic [127:0] ua, ub, lhs, rhs;
    if (na >= 0 && nb < 0) return 1'b1;
    if (na < 0 && nb >= 0) return 1'b0;
    ua  = (na < 0) ? -na : na;
    ub  = (nb < 0) ? -nb : nb;
    lhs = ua * ua * db;
    rhs = ub * ub * da;
    return (na >= 0) ? (lhs > rhs) : (lhs < rhs);
  endfunction

  task automatic absorb_pixel(input pix_word_t w);
    int     col, ctr, half, p, t, best;
    longint n, s, vf, m;
    longint num [NTPL];
    longint den [NTPL];
    bit     ok  [NTPL];
    col = w.column;
    ctr = w.center;
    p   = w.pixel;
    if (seg_len < MAX_SEGMENT) begin
      pix_sum += p;
      sq_sum  += p * p;
      for (t = 0; t < NTPL; t++) begin
        half = w.half[t];
        if (col >= ctr - half && col <= ctr + half) begin
          win_sum[t] += p;
          win_cnt[t] += 1;
        end
      end
      seg_len += 1;
    end
    if (w.last) begin
      n  = seg_len;
      s  = pix_sum;
      vf = n * longint'(sq_sum) - s * s;
      for (t = 0; t < NTPL; t++) begin
        m      = win_cnt[t];
        den[t] = m * (n - m);
        num[t] = n * longint'(win_sum[t]) - s * m;
        ok[t]  = (vf > 0) && (den[t] > 0);
      end
      best = 0;
      for (t = 1; t < NTPL; t++)
        if (ok[best] && ok[t] && corr_greater(num[t], den[t], num[best], den[best]))
          best = t;
      code_expect_q.push_back(CODE_W'(best));
      pix_sum = 0;
      sq_sum  = 0;
      seg_len = 0;
      for (t = 0; t < NTPL; t++) begin
        win_sum[t] = 0;
        win_cnt[t] = 0;
      end
    end
  endtask

  task automatic push_word(input int pix, input int col, input int ctr, input int hn,
                           input int hm, input int hw, input bit last, input bit drain);
    pix_word_t w;
    w.pixel       = PIX_W'(pix);
    w.column      = COL_W'(col);
    w.center      = COL_W'(ctr);
    w.half[0]     = HALF_W'(hn);
    w.half[1]     = HALF_W'(hm);
    w.half[2]     = HALF_W'(hw);
    w.last        = last;
    w.drain_first = drain;
    pixel_word_q.push_back(w);
    total_words++;
  endtask

  // two-level row: hi_val on offsets strip_lo..strip_hi, lo_val elsewhere
  task automatic push_span(input int left, input int len, input int ctr, input int hn,
                           input int hm, input int hw, input int strip_lo,
                           input int strip_hi, input int lo_val, input int hi_val);
    int i;
    for (i = 0; i < len; i++)
      push_word((i >= strip_lo && i <= strip_hi) ? hi_val : lo_val, left + i, ctr,
                hn, hm, hw, i == len - 1, 1'b0);
    seg_total++;
  endtask

  task automatic gen_segment(input int len, input seg_kind_t kind, input bit drain);
    int i, left, off, ctr, q, sh, tmp, base, bright, amp, val, col, c;
    int h [NTPL];
    left = (len <= MAX_SEGMENT) ? $urandom_range(0, MAX_SEGMENT - len)
                                : $urandom_range(0, MAX_SEGMENT - 1);
    off  = $urandom_range(0, len - 1);
    ctr  = (left + off) % MAX_SEGMENT;
    q    = len / 4;
    h[0] = $urandom_range(0, q);
    h[1] = h[0] + $urandom_range(0, q + 1);
    h[2] = h[1] + $urandom_range(0, q + 1);
    case ($urandom_range(0, 3))
      1: begin tmp = h[0]; h[0] = h[1]; h[1] = tmp; end
      2: begin tmp = h[1]; h[1] = h[2]; h[2] = tmp; end
      3: begin tmp = h[0]; h[0] = h[2]; h[2] = tmp; end
      default: ;
    endcase
    for (i = 0; i < NTPL; i++)
      h[i] = clamp(h[i], 1023);
    if (kind == SEG_NOISE) begin
      ctr = $urandom_range(0, 2047);
      for (i = 0; i < NTPL; i++)
        h[i] = $urandom_range(0, 1023);
    end
    sh     = $urandom_range(0, q + 1);
    base   = $urandom_range(0, 90);
    bright = $urandom_range(150, 255);
    amp    = $urandom_range(0, 40);
    if ($urandom_range(0, 3) == 0) begin
      tmp = base; base = bright; bright = tmp;  // dark marking on bright road
    end
    for (i = 0; i < len; i++) begin
      col = (left + i) % MAX_SEGMENT;
      c   = ctr;
      val = ((i > off ? i - off : off - i) <= sh) ? bright : base;
      val = clamp(val + int'($urandom_range(0, 2 * amp)) - amp, 255);
      case (kind)
        SEG_FLAT:  val = base;
        SEG_NOISE: val = $urandom_range(0, 255);
        SEG_JUMP:  if ($urandom_range(0, 1)) col = $urandom_range(0, 2047);
        SEG_DRIFT: begin
          c = (ctr + int'($urandom_range(0, 4)) - 2) & 11'h7ff;
          for (tmp = 0; tmp < NTPL; tmp++)
            h[tmp] = clamp(h[tmp] + int'($urandom_range(0, 2)) - 1, 1023);
        end
        default: ;
      endcase
      push_word(val, col, c, h[0], h[1], h[2], i == len - 1, drain && i == 0);
    end
    seg_total++;
  endtask

  // driver
  always @(posedge clk) begin : drive_blk
    bit        next_valid;
    pix_word_t nw;
    next_valid = in_valid;
    nw         = cur_word;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        absorb_pixel(cur_word);
        words_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pixel_word_q.size() > 0 &&
                     !(pixel_word_q[0].drain_first && code_expect_q.size() > 0)) begin
          nw         = pixel_word_q.pop_front();
          next_valid = 1'b1;
          if (!calm && pixel_word_q.size() > TAIL_WORDS && $urandom_range(0, 7) == 0)
            in_gap = $urandom_range(1, 9);
        end
      end
    end
    cur_word       <= nw;
    in_valid       <= next_valid;
    in_pixel       <= nw.pixel;
    in_column      <= nw.column;
    in_center      <= nw.center;
    in_half_narrow <= nw.half[0];
    in_half_middle <= nw.half[1];
    in_half_wide   <= nw.half[2];
    in_last        <= nw.last;
  end

  // result receiver with stall bursts
  always @(posedge clk) begin : recv_blk
    bit nr;
    nr = 1'b1;
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap--;
        nr = 1'b0;
      end else if (!calm && pixel_word_q.size() > TAIL_WORDS && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 8);
        nr      = 1'b0;
      end
      if ($urandom_range(0, 39) == 0)
        calm <= ~calm;
    end
    out_ready <= nr;
  end

  // code checker
  always @(posedge clk) begin : check_blk
    logic [CODE_W-1:0] exp_code;
    if (rst_n && out_valid && out_ready) begin
      codes_seen++;
      if (out_width_code < NTPL)
        code_hist[out_width_code]++;
      if (code_expect_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch: width_code %0d with none expected", out_width_code);
      end else begin
        exp_code = code_expect_q.pop_front();
        if (out_width_code !== exp_code) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: width_code expected %0d actual %0d (result %0d)",
                     exp_code, out_width_code, codes_seen);
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_box_template_zncc_width_select_core NOT OK");
        $finish;
      end
    end
  end

  initial begin : stim_blk
    int        rand_words, len, r, seg_idx;
    seg_kind_t kind;

    // directed rows
    push_span(2047, 1, 2047, 1023, 1023, 1023, 0, 0, 255, 255);  // single pixel
    push_span(0, 3, 0, 0, 0, 0, 0, 2, 128, 128);                 // flat row
    push_span(10, 6, 12, 1, 1, 1, 2, 3, 0, 255);                 // equal windows tie
    push_span(20, 5, 22, 0, 1, 5, 1, 3, 0, 255);                 // wide covers all
    push_span(40, 5, 42, 1023, 1, 0, 1, 3, 0, 255);              // narrow covers all
    push_span(60, 6, 62, 0, 1, 2, 0, 4, 10, 200);                // wide fits the strip

    rand_words = 0;
    seg_idx    = 0;
    while (rand_words < RANDOM_WORDS) begin
      r    = $urandom_range(0, 99);
      len  = (r < 75) ? $urandom_range(2, 24) : (r < 93) ? $urandom_range(25, 90) :
             (r < 96) ? 1 : $urandom_range(150, 400);
      r    = $urandom_range(0, 99);
      kind = (r < 70) ? SEG_BOX : (r < 76) ? SEG_FLAT : (r < 84) ? SEG_NOISE :
             (r < 92) ? SEG_JUMP : SEG_DRIFT;
      gen_segment(len, kind, seg_idx == 12);
      rand_words += len;
      seg_idx++;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (words_taken < total_words || code_expect_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (code_expect_q.size() != 0) begin
      fail_count++;
      $display("mismatch: %0d codes never arrived", code_expect_q.size());
    end

    $display("covered %0d rows (%0d pixel words), %0d codes checked",
             seg_total, words_taken, codes_seen);
    $display("codes seen: narrow %0d, middle %0d, wide %0d; failures %0d",
             code_hist[0], code_hist[1], code_hist[2], fail_count);
    if (fail_count == 0)
      $display("tb_box_template_zncc_width_select_core OK");
    else
      $display("tb_box_template_zncc_width_select_core NOT OK");
    $finish;
  end

endmodule
